FILE: rtl/binary_to_roman_numeral_encoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Roman numeral encoder
// Shared concurrent assertion forms, compiled away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_ROMAN_NUMERAL_ENCODER_MACROS_SVH
`define BINARY_TO_ROMAN_NUMERAL_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define B2R_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define B2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define B2R_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define B2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/b2r_pkg.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Types, microcode program, digit patterns and letter tables.
// ----------------------------------------------------------------------------
package b2r_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned SYMBOL_W = 8;
    localparam int unsigned STEP_W   = 3;
    localparam int unsigned WEIGHT_W = 14;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    localparam logic [SYMBOL_W-1:0] LETTER_I = 8'h49;
    localparam logic [SYMBOL_W-1:0] LETTER_V = 8'h56;
    localparam logic [SYMBOL_W-1:0] LETTER_X = 8'h58;
    localparam logic [SYMBOL_W-1:0] LETTER_L = 8'h4C;
    localparam logic [SYMBOL_W-1:0] LETTER_C = 8'h43;
    localparam logic [SYMBOL_W-1:0] LETTER_D = 8'h44;
    localparam logic [SYMBOL_W-1:0] LETTER_M = 8'h4D;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ZERO  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIGIT,
        OP_EMIT,
        OP_NEXT,
        OP_ERR
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_BAD,
        COND_NO_CHARS,
        COND_MORE_CHARS,
        COND_MORE_PLACES
    } cond_t;

    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN
    } sel_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic                push;
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        status_t             status;
    } b2r_char_t;

    // Control store. A true condition jumps to the target, otherwise the
    // step counter advances by one. While the output is blocked, the step holds.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t uw;
        unique case (step)
            3'd0:    uw = '{op: OP_LOAD,  cond: COND_NO_INPUT,    target: 3'd0};
            3'd1:    uw = '{op: OP_NOP,   cond: COND_BAD,         target: 3'd6};
            3'd2:    uw = '{op: OP_DIGIT, cond: COND_NO_CHARS,    target: 3'd4};
            3'd3:    uw = '{op: OP_EMIT,  cond: COND_MORE_CHARS,  target: 3'd3};
            3'd4:    uw = '{op: OP_NEXT,  cond: COND_MORE_PLACES, target: 3'd2};
            3'd5:    uw = '{op: OP_NOP,   cond: COND_ALWAYS,      target: 3'd0};
            3'd6:    uw = '{op: OP_ERR,   cond: COND_ALWAYS,      target: 3'd0};
            default: uw = '{op: OP_NOP,   cond: COND_ALWAYS,      target: 3'd0};
        endcase
        return uw;
    endfunction

    function automatic logic [WEIGHT_W-1:0] place_weight(input logic [1:0] place);
        logic [WEIGHT_W-1:0] w;
        unique case (place)
            2'd0:    w = 14'd1;
            2'd1:    w = 14'd10;
            2'd2:    w = 14'd100;
            default: w = 14'd1000;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] pattern_len(input logic [3:0] digit);
        logic [2:0] len;
        unique case (digit)
            4'd1, 4'd5:       len = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             len = 3'd2;
            4'd3, 4'd7:       len = 3'd3;
            4'd8:             len = 3'd4;
            default:          len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic sel_t pattern_sel(input logic [3:0] digit, input logic [1:0] idx);
        sel_t sel;
        if (idx == 2'd0)
        begin
            sel = (digit >= 4'd5 && digit <= 4'd8) ? SEL_FIVE : SEL_ONE;
        end
        else if (idx == 2'd1 && digit == 4'd4)
        begin
            sel = SEL_FIVE;
        end
        else if (idx == 2'd1 && digit == 4'd9)
        begin
            sel = SEL_TEN;
        end
        else
        begin
            sel = SEL_ONE;
        end
        return sel;
    endfunction

    function automatic logic [SYMBOL_W-1:0] place_letter(input logic [1:0] place,
                                                         input sel_t sel);
        logic [SYMBOL_W-1:0] ch;
        unique case (place)
            2'd0:    ch = (sel == SEL_ONE) ? LETTER_I : (sel == SEL_FIVE) ? LETTER_V : LETTER_X;
            2'd1:    ch = (sel == SEL_ONE) ? LETTER_X : (sel == SEL_FIVE) ? LETTER_L : LETTER_C;
            2'd2:    ch = (sel == SEL_ONE) ? LETTER_C : (sel == SEL_FIVE) ? LETTER_D : LETTER_M;
            default: ch = LETTER_M;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/b2r_sequencer.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder sequencer
// Microcoded control over a remainder, place and digit datapath that
// produces one numeral character per emit step.
// ----------------------------------------------------------------------------
module b2r_sequencer
    import b2r_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] value,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               out_free,
    output b2r_char_t          chr
);

    step_t              step_reg, step_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [1:0]         place_reg, place_next;
    logic [3:0]         digit_reg, digit_next;
    logic [1:0]         idx_reg, idx_next;

    ucode_t              uw;
    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] sub;
    logic [WEIGHT_W-1:0] multiple;
    logic [3:0]          digit_now;
    logic [2:0]          len;
    logic                cond_true;
    logic                blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        place_reg <= place_next;
        digit_reg <= digit_next;
        idx_reg   <= idx_next;
    end

    always_comb
    begin
        uw        = ucode_rom(step_reg);
        weight    = place_weight(place_reg);
        len       = pattern_len(digit_reg);
        digit_now = 4'd0;
        sub       = '0;
        for (int k = 1; k <= 9; k++)
        begin
            multiple = WEIGHT_W'(k) * weight;
            if ({2'b00, rem_reg} >= multiple)
            begin
                digit_now = 4'(k);
                sub       = multiple;
            end
        end

        rem_next   = rem_reg;
        place_next = place_reg;
        digit_next = digit_reg;
        idx_next   = idx_reg;
        blocked    = 1'b0;
        chr        = '{push: 1'b0, symbol: '0, last: 1'b0, status: STATUS_OK};

        unique case (uw.op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    rem_next   = value;
                    place_next = 2'd3;
                end
            end
            OP_DIGIT:
            begin
                digit_next = digit_now;
                idx_next   = 2'd0;
                rem_next   = rem_reg - sub[VALUE_W-1:0];
            end
            OP_EMIT:
            begin
                blocked    = !out_free;
                chr.push   = out_free;
                chr.symbol = place_letter(place_reg, pattern_sel(digit_reg, idx_reg));
                chr.last   = ({1'b0, idx_reg} == len - 3'd1) && (rem_reg == '0);
                if (out_free)
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            OP_NEXT:
            begin
                place_next = place_reg - 2'd1;
            end
            OP_ERR:
            begin
                blocked    = !out_free;
                chr.push   = out_free;
                chr.last   = 1'b1;
                chr.status = (rem_reg == '0) ? STATUS_ZERO : STATUS_RANGE;
            end
            default:
            begin
            end
        endcase

        unique case (uw.cond)
            COND_NO_INPUT:    cond_true = !in_valid;
            COND_BAD:         cond_true = (rem_reg == '0) || (rem_reg > MAX_VALUE);
            COND_NO_CHARS:    cond_true = (digit_now == 4'd0);
            COND_MORE_CHARS:  cond_true = ({1'b0, idx_reg} != len - 3'd1);
            COND_MORE_PLACES: cond_true = (place_reg != 2'd0) && (rem_reg != '0);
            default:          cond_true = 1'b1;
        endcase

        if (blocked)
        begin
            step_next = step_reg;
        end
        else if (cond_true)
        begin
            step_next = uw.target;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end

        in_stall = (uw.op != OP_LOAD);
    end

endmodule

FILE: rtl/binary_to_roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// Binary to Roman numeral encoder
// Converts a 12-bit value to its Roman numeral, one ASCII letter per transfer.
// ----------------------------------------------------------------------------
// One value is taken per transfer on the input channel; the numeral leaves
// most significant place first, one letter per output transfer, with last
// set on the final letter. Zero and values above 3999 give a single transfer
// with symbol 0, last set and an error status. A new value is taken only
// once the previous one has been fully sequenced by the microcode step
// counter, which handles one step per cycle while the output can take a
// letter and holds its step while it cannot. An output register lets the
// next value start while the last letter still waits.
`include "binary_to_roman_numeral_encoder_macros.svh"

module binary_to_roman_numeral_encoder
    import b2r_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [VALUE_W-1:0]  value,
    input  logic                in_valid,
    output logic                in_stall,
    output logic [SYMBOL_W-1:0] symbol,
    output logic                last,
    output logic [1:0]          status,
    output logic                out_valid,
    input  logic                out_stall
);

    b2r_char_t           chr;
    logic                out_free;
    logic                out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0] symbol_reg;
    logic                last_reg;
    status_t             status_reg;

    b2r_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_free (out_free),
        .chr      (chr)
    );

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        if (chr.push)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chr.push)
        begin
            symbol_reg <= chr.symbol;
            last_reg   <= chr.last;
            status_reg <= chr.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    `B2R_ASSERT_IMP(a_err_single, clk, rst_n, out_valid && (status != STATUS_OK), last && (symbol == '0))
    `B2R_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
    `B2R_ASSERT_IMP(a_ok_letter, clk, rst_n, out_valid && (status == STATUS_OK), (symbol == LETTER_I) || (symbol == LETTER_V) || (symbol == LETTER_X) || (symbol == LETTER_L) || (symbol == LETTER_C) || (symbol == LETTER_D) || (symbol == LETTER_M))

endmodule

FILE: bench/binary_to_roman_numeral_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral encoder testbench
// Sends values through the input channel under several idling patterns and
// checks every letter, last flag and status against a behavioral predictor.
// ----------------------------------------------------------------------------
module binary_to_roman_numeral_encoder_tb;
    import b2r_pkg::*;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        status_t             status;
    } numeral_letter_t;

    logic                clk;
    logic                rst_n;
    logic [VALUE_W-1:0]  value;
    logic                in_valid;
    logic                in_stall;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic [1:0]          status;
    logic                out_valid;
    logic                out_stall;

    numeral_letter_t pending_letters[$];
    numeral_letter_t want;
    int unsigned     error_count;
    int unsigned     quiet_cycles;
    int unsigned     sender_idle_pct;
    int unsigned     receiver_stall_pct;

    binary_to_roman_numeral_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .symbol    (symbol),
        .last      (last),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_letter(input logic [SYMBOL_W-1:0] ch);
        numeral_letter_t entry;
        entry.symbol = ch;
        entry.last   = 1'b0;
        entry.status = STATUS_OK;
        pending_letters.insert(pending_letters.size(), entry);
    endfunction

    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        logic [SYMBOL_W-1:0] one_letter[4];
        logic [SYMBOL_W-1:0] five_letter[4];
        logic [SYMBOL_W-1:0] ten_letter[4];
        numeral_letter_t     entry;
        int                  weight;
        int                  digit;
        one_letter  = '{LETTER_I, LETTER_X, LETTER_C, LETTER_M};
        five_letter = '{LETTER_V, LETTER_L, LETTER_D, LETTER_M};
        ten_letter  = '{LETTER_X, LETTER_C, LETTER_M, LETTER_M};
        entry.symbol = '0;
        entry.last   = 1'b1;
        if (v == '0)
        begin
            entry.status = STATUS_ZERO;
            pending_letters.insert(pending_letters.size(), entry);
        end
        else if (v > MAX_VALUE)
        begin
            entry.status = STATUS_RANGE;
            pending_letters.insert(pending_letters.size(), entry);
        end
        else
        begin
            weight = 1000;
            for (int place = 3; place >= 0; place--)
            begin
                digit = (int'(v) / weight) % 10;
                if (digit == 4 || digit == 9)
                begin
                    push_letter(one_letter[place]);
                    push_letter(digit == 4 ? five_letter[place] : ten_letter[place]);
                end
                else
                begin
                    if (digit >= 5)
                    begin
                        push_letter(five_letter[place]);
                    end
                    for (int k = 0; k < digit % 5; k++)
                    begin
                        push_letter(one_letter[place]);
                    end
                end
                weight = weight / 10;
            end
            pending_letters[$].last = 1'b1;
        end
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            value    <= VALUE_W'($urandom);
        end
        @(negedge clk);
        value    <= v;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_numeral(v);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            return '0;
        end
        else if (pick < 12)
        begin
            return VALUE_W'($urandom_range(4000, 4095));
        end
        return VALUE_W'($urandom_range(1, 3999));
    endfunction

    task automatic send_random_values(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_value(random_value());
        end
    endtask

    task automatic test_directed_values();
        logic [VALUE_W-1:0] picks[$];
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        picks = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
                  12'd40, 12'd90, 12'd400, 12'd900, 12'd1994, 12'd5, 12'd10, 12'd50,
                  12'd100, 12'd500, 12'd1000, 12'd3000, 12'd444, 12'd999, 12'd2048,
                  12'd1111, 12'd2730};
        foreach (picks[i])
        begin
            send_value(picks[i]);
        end
    endtask

    task automatic test_back_to_back();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_random_values(72);
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct    = 64;
        receiver_stall_pct = 0;
        send_random_values(72);
    endtask

    task automatic test_receiver_stalls();
        sender_idle_pct    = 0;
        receiver_stall_pct = 64;
        send_random_values(72);
    endtask

    task automatic test_mixed_idling();
        sender_idle_pct    = 35;
        receiver_stall_pct = 35;
        send_random_values(72);
    endtask

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_letters.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual symbol %h last %b status %0d",
                         $time, symbol, last, status);
                error_count++;
            end
            else
            begin
                want = pending_letters.pop_front();
                if (symbol !== want.symbol)
                begin
                    $display("%0t: symbol expected %h actual %h", $time, want.symbol, symbol);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, last);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("binary_to_roman_numeral_encoder_tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        value              = '0;
        in_valid           = 1'b0;
        out_stall          = 1'b0;
        error_count        = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_values();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_letters.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("binary_to_roman_numeral_encoder_tb passed");
        end
        else
        begin
            $display("binary_to_roman_numeral_encoder_tb failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/b2r_pkg.sv
rtl/b2r_sequencer.sv
rtl/binary_to_roman_numeral_encoder.sv
bench/binary_to_roman_numeral_encoder_tb.sv
